[src/lbmp_pkg.sv]
// Package for the Lucas binomial block: shared widths.
// No dependencies.
`default_nettype none
package lbmp_pkg;
	localparam int unsigned RES_W = 12;
	localparam int unsigned N_W = 63;
	localparam int unsigned K_W = 64;
endpackage
`default_nettype wire

[src/lbmp_divmod.sv]
// Shared iterative divider: divides n and k by p together, one quotient bit a cycle,
// giving both quotients and remainders after N_W steps. Uses lbmp_pkg.
`default_nettype none
module lbmp_divmod
	import lbmp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [N_W-1:0]   n_in,
	input  wire logic [N_W-1:0]   k_in,
	input  wire logic [RES_W:0]   p,
	output logic                  done,
	output logic [N_W-1:0]        n_quo,
	output logic [N_W-1:0]        k_quo,
	output logic [RES_W:0]        n_rem,
	output logic [RES_W:0]        k_rem
);
	logic [N_W-1:0] nq_q, kq_q;
	logic [RES_W:0] nr_q, kr_q;
	logic [5:0]     cnt_q;
	logic           run_q;
	logic [RES_W+1:0] nt, kt;

	// shift in the next dividend bit, subtract when it fits
	assign nt = {nr_q, nq_q[N_W-1]};
	assign kt = {kr_q, kq_q[N_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(N_W - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			nq_q <= n_in;
			kq_q <= k_in;
			nr_q <= '0;
			kr_q <= '0;
		end else if (run_q) begin
			if (nt >= {1'b0, p}) begin
				nr_q <= (RES_W+1)'(nt - {1'b0, p});
				nq_q <= {nq_q[N_W-2:0], 1'b1};
			end else begin
				nr_q <= nt[RES_W:0];
				nq_q <= {nq_q[N_W-2:0], 1'b0};
			end
			if (kt >= {1'b0, p}) begin
				kr_q <= (RES_W+1)'(kt - {1'b0, p});
				kq_q <= {kq_q[N_W-2:0], 1'b1};
			end else begin
				kr_q <= kt[RES_W:0];
				kq_q <= {kq_q[N_W-2:0], 1'b0};
			end
		end
	end

	assign n_quo = nq_q;
	assign k_quo = kq_q;
	assign n_rem = nr_q;
	assign k_rem = kr_q;
endmodule
`default_nettype wire

[src/lbmp_mulmod.sv]
// Shared modular multiplier: (a*b) mod p by MSB-first shift-add, one bit a cycle.
// Uses lbmp_pkg.
`default_nettype none
module lbmp_mulmod
	import lbmp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [RES_W-1:0] a,
	input  wire logic [RES_W:0]   b,
	input  wire logic [RES_W:0]   p,
	output logic                  done,
	output logic [RES_W-1:0]      prod
);
	logic [RES_W-1:0] a_q;
	logic [RES_W:0]   b_q;
	logic [RES_W:0]   acc_q;
	logic [3:0]       cnt_q;
	logic             run_q;
	logic [RES_W+2:0] dbl, dbl_r, add, add_r;

	// acc = 2*acc mod p, then add a bit of b times a, reduce again
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {2'b0, p}) ? dbl - {2'b0, p} : dbl;
		add   = dbl_r + (b_q[RES_W] ? {3'b0, a_q} : '0);
		add_r = (add >= {2'b0, p}) ? add - {2'b0, p} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(RES_W)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= add_r[RES_W:0];
			b_q   <= {b_q[RES_W-1:0], 1'b0};
		end
	end

	assign prod = acc_q[RES_W-1:0];
endmodule
`default_nettype wire

[src/lucas_binomial_mod_prime.sv]
// Top level of the Lucas binomial block: table memories, table build and query
// sequencer. Uses lbmp_pkg, lbmp_divmod and lbmp_mulmod.
//
// Computes C(n,k) mod p by Lucas's theorem. Writing the modulus rebuilds the
// factorial and inverse-factorial memories; busy stays high during the build
// (p clamped to 2..TABLE_DEPTH), also after reset for p = 2. A query with
// k < 0, k > n or k = 0 answers the cycle after it is taken. Otherwise each
// base-p digit takes a pass of the shared divider, reads of both memories and
// three passes of the bit-serial multiplier, so a query runs longer the more
// digits k has (up to 63 digits at p = 2). The answer stays on residue until
// the next result and done marks it for one cycle; done cannot be held.
`default_nettype none
module lucas_binomial_mod_prime
	import lbmp_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [N_W-1:0]   top_n,
	input  wire logic [K_W-1:0]   choose_k,
	output logic                  done,
	output logic [RES_W-1:0]      residue,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [RES_W-1:0] cfg_data
);
	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned PW = AW + 1;

	typedef enum logic [4:0] {
		S_IDLE, S_F_MUL, S_F_WAIT, S_E_INIT, S_E_SQ, S_E_SQW, S_E_ML, S_E_MLW,
		S_I_RD, S_I_RDW, S_I_MUL, S_I_WAIT, S_Q_DIV, S_Q_DIVW, S_Q_RD, S_Q_RDW,
		S_Q_M1, S_Q_M1W, S_Q_M2, S_Q_M2W, S_Q_M3, S_Q_M3W, S_DONE
	} state_t;

	state_t state_q;

	logic [RES_W-1:0] fact_mem [TABLE_DEPTH];
	logic [RES_W-1:0] ifact_mem [TABLE_DEPTH];

	logic [RES_W:0]   p_q;       // effective modulus
	logic [PW-1:0]    idx_q;
	logic [RES_W-1:0] acc_q;     // running value
	logic [RES_W-1:0] base_q;
	logic [RES_W:0]   exp_q;
	logic [N_W-1:0]   n_q, k_q;
	logic [RES_W:0]   ra_q, rb_q;
	logic [RES_W-1:0] fa_q, ib_q, iab_q;

	logic             f_we, i_we;
	logic [AW-1:0]    f_wa, i_wa, f_ra, i_ra1, i_ra2;
	logic [RES_W-1:0] f_wd, i_wd;
	logic [RES_W-1:0] f_rd_q, i_rd1_q, i_rd2_q;

	logic             dv_go, dv_done;
	logic [N_W-1:0]   nq, kq;
	logic [RES_W:0]   nr, kr;
	logic             mm_go, mm_done;
	logic [RES_W-1:0] mm_a, mm_p_out;
	logic [RES_W:0]   mm_b;
	logic [RES_W:0]   p_eff;

	// clamp the written modulus to 2..TABLE_DEPTH
	always_comb begin
		if ({1'b0, cfg_data} < (RES_W+1)'(2))
			p_eff = (RES_W+1)'(2);
		else if (32'(cfg_data) > TABLE_DEPTH)
			p_eff = (RES_W+1)'(TABLE_DEPTH);
		else
			p_eff = {1'b0, cfg_data};
	end

	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign busy = (state_q != S_IDLE);

	lbmp_divmod u_div (
		.clk, .arst_n, .go(dv_go), .n_in(n_q), .k_in(k_q), .p(p_q),
		.done(dv_done), .n_quo(nq), .k_quo(kq), .n_rem(nr), .k_rem(kr)
	);

	lbmp_mulmod u_mul (
		.clk, .arst_n, .go(mm_go), .a(mm_a), .b(mm_b), .p(p_q),
		.done(mm_done), .prod(mm_p_out)
	);

	// memories: one write port, registered reads
	always_ff @(posedge clk) begin
		if (f_we)
			fact_mem[f_wa] <= f_wd;
		f_rd_q <= fact_mem[f_ra];
	end

	always_ff @(posedge clk) begin
		if (i_we)
			ifact_mem[i_wa] <= i_wd;
		i_rd1_q <= ifact_mem[i_ra1];
		i_rd2_q <= ifact_mem[i_ra2];
	end

	always_comb begin
		f_we  = 1'b0;
		i_we  = 1'b0;
		f_wa  = idx_q[AW-1:0];
		i_wa  = idx_q[AW-1:0];
		f_wd  = acc_q;
		i_wd  = acc_q;
		f_ra  = ra_q[AW-1:0];
		i_ra1 = rb_q[AW-1:0];
		i_ra2 = AW'(ra_q - rb_q);
		dv_go = 1'b0;
		mm_go = 1'b0;
		mm_a  = acc_q;
		mm_b  = {1'b0, base_q};
		unique case (state_q)
			S_F_MUL: begin
				mm_go = 1'b1;
				mm_b  = (RES_W+1)'(idx_q);
			end
			S_E_SQ: begin
				mm_go = 1'b1;
				mm_a  = base_q;
			end
			S_E_ML: mm_go = exp_q[0];
			// read again after the seed write lands
			S_I_RD, S_I_RDW: i_ra1 = idx_q[AW-1:0];
			S_I_MUL: begin
				mm_go = 1'b1;
				mm_a  = i_rd1_q;
				mm_b  = (RES_W+1)'(idx_q);
			end
			S_Q_DIV: dv_go = 1'b1;
			S_Q_M1: begin
				mm_go = 1'b1;
				mm_a  = fa_q;
				mm_b  = {1'b0, ib_q};
			end
			S_Q_M2: begin
				mm_go = 1'b1;
				mm_a  = base_q;
				mm_b  = {1'b0, iab_q};
			end
			S_Q_M3: begin
				mm_go = 1'b1;
				mm_b  = {1'b0, base_q};
			end
			default: ;
		endcase
		if (state_q == S_F_WAIT && mm_done) begin
			f_we = 1'b1;
			f_wd = mm_p_out;
		end
		if (state_q == S_E_INIT) begin
			// entry zero of fact is 1 before the first multiply
			f_we = (idx_q == '0);
			f_wd = RES_W'(1);
		end
		if (state_q == S_I_WAIT && mm_done) begin
			i_we = 1'b1;
			i_wa = AW'(idx_q - PW'(1));
			i_wd = mm_p_out;
		end
		if (state_q == S_I_RD && exp_q == '0 && idx_q == PW'(p_q - 1)) begin
			// seed top inverse with the power result
			i_we = 1'b1;
			i_wa = idx_q[AW-1:0];
			i_wd = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_E_INIT;
			p_q     <= (RES_W+1)'(2);
			idx_q   <= '0;
			acc_q   <= RES_W'(1);
			done    <= 1'b0;
			residue <= '0;
			exp_q   <= '0;
			base_q  <= '0;
			n_q     <= '0;
			k_q     <= '0;
			ra_q    <= '0;
			rb_q    <= '0;
			fa_q    <= '0;
			ib_q    <= '0;
			iab_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						p_q     <= p_eff;
						idx_q   <= '0;
						acc_q   <= RES_W'(1);
						state_q <= S_E_INIT;
					end else if (start) begin
						n_q   <= top_n;
						k_q   <= choose_k[N_W-1:0];
						acc_q <= RES_W'(1);
						if (choose_k[K_W-1] || choose_k[N_W-1:0] > top_n) begin
							residue <= '0;
							done    <= 1'b1;
						end else if (choose_k[N_W-1:0] == '0) begin
							residue <= RES_W'(1);
							done    <= 1'b1;
						end else begin
							state_q <= S_Q_DIV;
						end
					end
				end
				// factorial build: entry 0 written here, then i from 1
				S_E_INIT: begin
					acc_q   <= RES_W'(1);
					idx_q   <= PW'(1);
					state_q <= (p_q > (RES_W+1)'(1)) ? S_F_MUL : S_IDLE;
				end
				S_F_MUL: state_q <= S_F_WAIT;
				S_F_WAIT: if (mm_done) begin
					acc_q <= mm_p_out;
					if ((RES_W+1)'(idx_q) == p_q - 1) begin
						// (p-1)! ready: raise to p-2
						base_q  <= mm_p_out;
						exp_q   <= p_q - (RES_W+1)'(2);
						acc_q   <= RES_W'(1);
						state_q <= S_E_ML;
					end else begin
						idx_q   <= idx_q + PW'(1);
						state_q <= S_F_MUL;
					end
				end
				// right-to-left power: multiply when bit set, then square
				S_E_ML: begin
					if (exp_q == '0) begin
						idx_q   <= PW'(p_q - 1);
						state_q <= S_I_RD;
					end else if (exp_q[0]) begin
						state_q <= S_E_MLW;
					end else begin
						state_q <= S_E_SQ;
					end
				end
				S_E_MLW: if (mm_done) begin
					acc_q   <= mm_p_out;
					state_q <= S_E_SQ;
				end
				S_E_SQ: state_q <= S_E_SQW;
				S_E_SQW: if (mm_done) begin
					base_q  <= mm_p_out;
					exp_q   <= exp_q >> 1;
					state_q <= S_E_ML;
				end
				// inverse walk down: inv[i-1] = inv[i]*i
				S_I_RD: begin
					exp_q <= (RES_W+1)'(1);
					if (idx_q == '0)
						state_q <= S_IDLE;
					else
						state_q <= S_I_RDW;
				end
				S_I_RDW: state_q <= S_I_MUL;
				S_I_MUL: state_q <= S_I_WAIT;
				S_I_WAIT: if (mm_done) begin
					idx_q   <= idx_q - PW'(1);
					state_q <= S_I_RD;
				end
				// query: one digit per pass
				S_Q_DIV: state_q <= S_Q_DIVW;
				S_Q_DIVW: if (dv_done) begin
					if (kr > nr) begin
						residue <= '0;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ra_q    <= nr;
						rb_q    <= kr;
						n_q     <= nq;
						k_q     <= kq;
						state_q <= S_Q_RD;
					end
				end
				S_Q_RD: state_q <= S_Q_RDW;
				S_Q_RDW: begin
					fa_q    <= f_rd_q;
					ib_q    <= i_rd1_q;
					iab_q   <= i_rd2_q;
					state_q <= S_Q_M1;
				end
				S_Q_M1: state_q <= S_Q_M1W;
				S_Q_M1W: if (mm_done) begin
					base_q  <= mm_p_out;
					state_q <= S_Q_M2;
				end
				S_Q_M2: state_q <= S_Q_M2W;
				S_Q_M2W: if (mm_done) begin
					base_q  <= mm_p_out;
					state_q <= S_Q_M3;
				end
				S_Q_M3: state_q <= S_Q_M3W;
				S_Q_M3W: if (mm_done) begin
					if (k_q == '0) begin
						residue <= mm_p_out;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						acc_q   <= mm_p_out;
						state_q <= S_Q_DIV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the multiplier is only started from an issue state
	assert property (@(posedge clk) disable iff (!arst_n)
		mm_go |=> !mm_go) else $error("multiplier restarted back to back");
	// a result is only given when leaving work or from idle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("result while busy");
	// the modulus never leaves its clamped range
	assert property (@(posedge clk) disable iff (!arst_n)
		p_q >= (RES_W+1)'(2)) else $error("modulus below two");
	// configuration is never taken during a query
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("config ready while busy");
endmodule
`default_nettype wire
